[hdl/tffla_pkg.sv]
package tffla_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_SLACK   = 1'd1;

	localparam int KIB = 1024;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LIST_FULL    = 2'd2;

	typedef struct packed {
		logic load;
		logic push;
		logic scan_step;
		logic fetch_last;
		logic move;
		logic bump;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic resize;
		logic hit;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

[hdl/tolerant_fit_free_list_allocator_top.sv]
// Free-list allocator with a bump pointer. Each request frees a block (command 0, or a resize
// to size zero) or resizes it: the old block is pushed onto an unsorted list of up to
// FREE_SLOTS entries, the list is scanned from entry 0 for the first entry whose size lies
// within the request plus fit_slack, and failing that the space is taken from the bump
// pointer, bounded by region_size. A free ends after the push; a resize then scans the list
// one entry per cycle through the single read port of the list memory. One request is
// handled at a time, and a finished result waits in an output register without holding up
// the next request until that request's own result is ready. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module tolerant_fit_free_list_allocator_top #(
	parameter int ADDR_BITS  = 24,
	parameter int FREE_SLOTS = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// Fields from bit 0: command, block_offset, block_size, request_size, zero fill.
	input  logic [((3*ADDR_BITS+1+7)/8)*8-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// Fields from bit 0: new_offset, size, status, zero fill.
	output logic [((2*ADDR_BITS+2+7)/8)*8-1:0]     m_tdata,
	input  logic                                   cfg_we,
	input  logic [tffla_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ADDR_BITS:0]                     cfg_data
);
	import tffla_pkg::*;

	localparam int OUT_W = ((2*ADDR_BITS+2+7)/8)*8;
	localparam int PAD_W = OUT_W - (2*ADDR_BITS + STATUS_W);

	dp_cmd_t              cmd;
	dp_stat_t             stat;
	logic [ADDR_BITS-1:0] new_offset, grant_size;
	logic [STATUS_W-1:0]  status;

	tffla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tffla_dp #(
		.ADDR_BITS  (ADDR_BITS),
		.FREE_SLOTS (FREE_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_command      (s_tdata[0]),
		.in_block_offset (s_tdata[ADDR_BITS:1]),
		.in_block_size   (s_tdata[2*ADDR_BITS:ADDR_BITS+1]),
		.in_request_size (s_tdata[3*ADDR_BITS:2*ADDR_BITS+1]),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_new_offset  (new_offset),
		.out_new_size    (grant_size),
		.out_status      (status)
	);

	assign m_tdata = {{PAD_W{1'b0}}, status, grant_size, new_offset};

endmodule

[hdl/tffla_ctrl.sv]
module tffla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  tffla_pkg::dp_stat_t stat,
	output tffla_pkg::dp_cmd_t  cmd
);
	import tffla_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PUSH  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_FETCH = 7'b0001000,
		S_MOVE  = 7'b0010000,
		S_BUMP  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = stat.resize ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.hit) begin
					state_d = S_FETCH;
				end else if (stat.scan_done) begin
					state_d = S_BUMP;
				end
			end
			S_FETCH: begin
				cmd.fetch_last = 1'b1;
				state_d        = S_MOVE;
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				state_d  = S_DONE;
			end
			S_BUMP: begin
				cmd.bump = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/tffla_dp.sv]
module tffla_dp #(
	parameter int ADDR_BITS  = 24,
	parameter int FREE_SLOTS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tffla_pkg::dp_cmd_t                   cmd,
	output tffla_pkg::dp_stat_t                  stat,
	input  logic                                 in_command,
	input  logic [ADDR_BITS-1:0]                 in_block_offset,
	input  logic [ADDR_BITS-1:0]                 in_block_size,
	input  logic [ADDR_BITS-1:0]                 in_request_size,
	input  logic                                 cfg_we,
	input  logic [tffla_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ADDR_BITS:0]                   cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ADDR_BITS-1:0]                 out_new_offset,
	output logic [ADDR_BITS-1:0]                 out_new_size,
	output logic [tffla_pkg::STATUS_W-1:0]       out_status
);
	import tffla_pkg::*;

	localparam int IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int CNT_W = $clog2(FREE_SLOTS + 1);
	localparam int ENT_W = 2 * ADDR_BITS;
	localparam logic [ADDR_BITS:0] REGION_MAX = {1'b1, {ADDR_BITS{1'b0}}};
	localparam logic [CNT_W-1:0]   SLOTS_CNT  = CNT_W'(FREE_SLOTS);

	logic [ENT_W-1:0] mem_q [FREE_SLOTS];

	logic [ADDR_BITS:0]   region_q;
	logic [ADDR_BITS-1:0] slack_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_BITS:0]   bump_q;

	logic [ADDR_BITS-1:0] boff_q, bsize_q, req_q;
	logic [ADDR_BITS:0]   hi_q;
	logic                 resize_q;
	logic                 list_full_q;
	logic                 oos_q;
	logic [ADDR_BITS-1:0] res_off_q, res_size_q;

	logic [CNT_W-1:0]     issue_q;
	logic                 rd_valid_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [ENT_W-1:0]     rd_data_s1;
	logic [IDX_W-1:0]     hit_idx_q;

	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] out_off_q, out_size_q;
	logic [STATUS_W-1:0]  out_status_q;

	logic                 list_full;
	logic                 push_we;
	logic                 mem_we;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENT_W-1:0]     wr_data;
	logic [IDX_W-1:0]     rd_addr;
	logic [CNT_W-1:0]     last_cnt;
	logic [ADDR_BITS-1:0] rd_off, rd_size;
	logic                 fits;
	logic                 issue_more;
	logic [ADDR_BITS:0]   limit;
	logic [ADDR_BITS+1:0] bump_sum;

	assign list_full  = (count_q == SLOTS_CNT);
	assign push_we    = cmd.push && (bsize_q != '0) && !list_full;
	assign mem_we     = push_we || cmd.move;
	assign wr_addr    = cmd.move ? hit_idx_q : count_q[IDX_W-1:0];
	assign wr_data    = cmd.move ? rd_data_s1 : {boff_q, bsize_q};
	assign last_cnt   = count_q - CNT_W'(1);
	assign rd_addr    = cmd.fetch_last ? last_cnt[IDX_W-1:0] : issue_q[IDX_W-1:0];
	assign rd_off     = rd_data_s1[ENT_W-1:ADDR_BITS];
	assign rd_size    = rd_data_s1[ADDR_BITS-1:0];
	assign fits       = rd_valid_s1 && (rd_size >= req_q) && ({1'b0, rd_size} <= hi_q);
	assign issue_more = (issue_q < count_q);
	assign limit      = (region_q > REGION_MAX) ? REGION_MAX : region_q;
	assign bump_sum   = {1'b0, bump_q} + {2'b00, req_q};

	assign stat.resize    = resize_q;
	assign stat.hit       = fits;
	assign stat.scan_done = !rd_valid_s1 && !issue_more;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign out_new_offset = out_off_q;
	assign out_new_size   = out_size_q;
	assign out_status     = out_status_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q    <= REGION_MAX;
			slack_q     <= ADDR_BITS'(KIB);
			count_q     <= '0;
			bump_q      <= '0;
			list_full_q <= 1'b0;
			oos_q       <= 1'b0;
			resize_q    <= 1'b0;
			issue_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_REGION_SIZE: region_q <= cfg_data;
					CFG_FIT_SLACK:   slack_q  <= cfg_data[ADDR_BITS-1:0];
					default:         region_q <= region_q;
				endcase
			end

			if (cmd.load) begin
				resize_q    <= in_command && (in_request_size != '0);
				list_full_q <= 1'b0;
				oos_q       <= 1'b0;
			end

			if (cmd.push) begin
				if (bsize_q != '0 && list_full) begin
					list_full_q <= 1'b1;
				end
				if (push_we) begin
					count_q <= count_q + CNT_W'(1);
				end
				issue_q     <= '0;
				rd_valid_s1 <= 1'b0;
			end

			if (cmd.scan_step) begin
				rd_valid_s1 <= issue_more;
				if (issue_more) begin
					issue_q <= issue_q + CNT_W'(1);
				end
			end

			if (cmd.move) begin
				count_q <= last_cnt;
			end

			if (cmd.bump) begin
				if (bump_sum > {1'b0, limit}) begin
					oos_q <= 1'b1;
				end else begin
					bump_q <= bump_sum[ADDR_BITS:0];
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			boff_q     <= in_block_offset;
			bsize_q    <= in_block_size;
			req_q      <= in_request_size;
			hi_q       <= {1'b0, in_request_size} + {1'b0, slack_q};
			res_off_q  <= '0;
			res_size_q <= '0;
		end
		if (cmd.scan_step) begin
			rd_idx_s1 <= issue_q[IDX_W-1:0];
		end
		if (cmd.scan_step && fits) begin
			hit_idx_q  <= rd_idx_s1;
			res_off_q  <= rd_off;
			res_size_q <= rd_size;
		end
		if (cmd.bump && !(bump_sum > {1'b0, limit})) begin
			res_off_q  <= bump_q[ADDR_BITS-1:0];
			res_size_q <= req_q;
		end
		if (cmd.emit) begin
			out_off_q    <= oos_q ? '0 : res_off_q;
			out_size_q   <= oos_q ? '0 : res_size_q;
			out_status_q <= oos_q ? ST_OUT_OF_SPACE : (list_full_q ? ST_LIST_FULL : ST_OK);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SLOTS_CNT)
		else $error("Free list count exceeds the number of slots.");

	a_bump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= REGION_MAX)
		else $error("Bump pointer has passed the end of the address space.");

	a_move_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |=> (count_q == $past(last_cnt)))
		else $error("Taking a free entry did not shorten the list by one.");

	a_full_push_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && list_full) |=> (count_q == SLOTS_CNT && list_full_q == (bsize_q != '0)))
		else $error("A push into a full list was not dropped and flagged.");
`endif

endmodule
